/* rtl/core/bums_pkg.sv */
// -----------------------------------------------------------------------------
// bums_pkg
// Shared types and constants for the bottom-up merge sort block.
// -----------------------------------------------------------------------------
package bums_pkg;

	// element width on both streams
	localparam int DATA_W = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_RUN_INIT,
		ST_MERGE,
		ST_EMIT
	} bums_state_t;

	// one sorted element handed from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              ovf;
		logic [DATA_W-1:0] value;
	} bums_item_t;

endpackage

/* rtl/core/bottom_up_merge_sort.sv */
// A set is loaded, then merged in ceil(log2 n) passes through one shared compare
// unit, ping-ponging between the two buffers, then streamed out.
// Input is taken one element per cycle while loading; merging and output block it.
// Reset (arst_n low) clears the sequencer and output valid; the buffers are not
// cleared, since only entries written in the current set are ever read.
// -----------------------------------------------------------------------------
// bottom_up_merge_sort
// Stable ascending sort of a set of signed elements, streamed in and out.
// -----------------------------------------------------------------------------
module bottom_up_merge_sort #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bums_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
	input  logic                          s_tlast,
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bums_pkg::DATA_W-1:0]   m_tdata,   // [31:0] sorted_value
	output logic                          m_tlast,
	output logic                          m_tuser    // [0] overflow
);
	import bums_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);

	logic [DATA_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1, wdata;
	logic [AW-1:0]     raddr0, raddr1, waddr;
	logic              we_a, we_b, out_free;
	bums_item_t        item;

	// ping-pong element buffers
	bums_ram #(.DEPTH(MAX_ITEMS)) u_ram_a (
		.clk    (clk),
		.we     (we_a),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd_a0),
		.rdata1 (rd_a1)
	);

	bums_ram #(.DEPTH(MAX_ITEMS)) u_ram_b (
		.clk    (clk),
		.we     (we_b),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd_b0),
		.rdata1 (rd_b1)
	);

	// sequencer and compare unit
	bums_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.rd_a0    (rd_a0),
		.rd_a1    (rd_a1),
		.rd_b0    (rd_b0),
		.rd_b1    (rd_b1),
		.raddr0   (raddr0),
		.raddr1   (raddr1),
		.we_a     (we_a),
		.we_b     (we_b),
		.waddr    (waddr),
		.wdata    (wdata),
		.out_free (out_free),
		.out_item (item)
	);

	// output register, refilled as soon as the pending transaction completes
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && item.valid) begin
			m_tdata <= item.value;
			m_tlast <= item.last;
			m_tuser <= item.ovf;
		end
	end

endmodule

/* rtl/core/bums_ram.sv */
// -----------------------------------------------------------------------------
// bums_ram
// Element buffer: one write port, two read ports with registered read data.
// -----------------------------------------------------------------------------
module bums_ram #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic [bums_pkg::DATA_W-1:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0]          raddr0,
	input  logic [$clog2(DEPTH)-1:0]          raddr1,
	output logic [bums_pkg::DATA_W-1:0]       rdata0,
	output logic [bums_pkg::DATA_W-1:0]       rdata1
);
	import bums_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

/* rtl/core/bums_ctrl.sv */
// -----------------------------------------------------------------------------
// bums_ctrl
// Sequencer with the shared compare unit: loads elements, runs the merge
// passes ping-ponging between the two buffers, then streams the result out.
// -----------------------------------------------------------------------------
module bums_ctrl #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bums_pkg::DATA_W-1:0]       in_value,
	input  logic                              in_last,
	// buffer read data (port 0 follows p, port 1 follows q)
	input  logic [bums_pkg::DATA_W-1:0]       rd_a0,
	input  logic [bums_pkg::DATA_W-1:0]       rd_a1,
	input  logic [bums_pkg::DATA_W-1:0]       rd_b0,
	input  logic [bums_pkg::DATA_W-1:0]       rd_b1,
	output logic [$clog2(MAX_ITEMS)-1:0]      raddr0,
	output logic [$clog2(MAX_ITEMS)-1:0]      raddr1,
	// buffer write side
	output logic                              we_a,
	output logic                              we_b,
	output logic [$clog2(MAX_ITEMS)-1:0]      waddr,
	output logic [bums_pkg::DATA_W-1:0]       wdata,
	// result side
	input  logic                              out_free,
	output bums_pkg::bums_item_t              out_item
);
	import bums_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	bums_state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;
	logic          drop_q, drop_d;
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] width_q, width_d;
	logic [CW-1:0] start_q, start_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [CW-1:0] p_q, p_d;
	logic [CW-1:0] q_q, q_d;
	logic [CW-1:0] k_q, k_d;
	logic          par_q, par_d;

	logic              accept, room, take_q, run_end, pass_end, more_pass;
	logic              emit_go, emit_last;
	logic [CW-1:0]     cnt_inc, n_new, k_inc, p_inc, q_inc, mid_new, hi_new;
	logic [SW-1:0]     st_w, st_2w, w2;
	logic [DATA_W-1:0] src_p, src_q;

	// shared compare unit and pointer arithmetic
	always_comb begin
		accept    = in_valid && (state_q == ST_LOAD);
		room      = cnt_q < MAX_CNT;
		cnt_inc   = cnt_q + 1'b1;
		n_new     = room ? cnt_inc : cnt_q;
		src_p     = par_q ? rd_b0 : rd_a0;
		src_q     = par_q ? rd_b1 : rd_a1;
		// right head wins when the left run is exhausted or when strictly smaller, keeping the sort stable
		take_q    = (p_q >= mid_q) ||
			((q_q < hi_q) && ($signed(src_q) < $signed(src_p)));
		k_inc     = k_q + 1'b1;
		p_inc     = p_q + 1'b1;
		q_inc     = q_q + 1'b1;
		run_end   = (k_inc == hi_q);
		pass_end  = (hi_q == n_q);
		w2        = {{(SW-CW){1'b0}}, width_q} << 1;
		more_pass = w2 < {{(SW-CW){1'b0}}, n_q};
		st_w      = {{(SW-CW){1'b0}}, start_q} + {{(SW-CW){1'b0}}, width_q};
		st_2w     = st_w + {{(SW-CW){1'b0}}, width_q};
		mid_new   = (st_w > {{(SW-CW){1'b0}}, n_q}) ? n_q : st_w[CW-1:0];
		hi_new    = (st_2w > {{(SW-CW){1'b0}}, n_q}) ? n_q : st_2w[CW-1:0];
		emit_go   = (state_q == ST_EMIT) && out_free;
		emit_last = (p_inc == n_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && in_last) state_d = ST_START;
			end
			ST_START: begin
				state_d = (n_q > CW'(1)) ? ST_RUN_INIT : ST_EMIT;
			end
			ST_RUN_INIT: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (run_end) begin
					if (pass_end && !more_pass) state_d = ST_EMIT;
					else                        state_d = ST_RUN_INIT;
				end
			end
			ST_EMIT: begin
				if (emit_go && emit_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// datapath updates and buffer control
	always_comb begin
		cnt_d   = cnt_q;
		drop_d  = drop_q;
		n_d     = n_q;
		width_d = width_q;
		start_d = start_q;
		mid_d   = mid_q;
		hi_d    = hi_q;
		p_d     = p_q;
		q_d     = q_q;
		k_d     = k_q;
		par_d   = par_q;
		we_a    = 1'b0;
		we_b    = 1'b0;
		waddr   = cnt_q[AW-1:0];
		wdata   = in_value;
		out_item        = '0;
		out_item.ovf    = drop_q;
		out_item.last   = emit_last;
		out_item.value  = src_p;
		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (room) begin
						cnt_d = cnt_inc;
						we_a  = 1'b1;
					end else begin
						drop_d = 1'b1;
					end
					if (in_last) begin
						n_d     = n_new;
						width_d = CW'(1);
						start_d = '0;
						par_d   = 1'b0;
					end
				end
			end
			ST_START: begin
				p_d = '0;
			end
			ST_RUN_INIT: begin
				mid_d = mid_new;
				hi_d  = hi_new;
				p_d   = start_q;
				q_d   = mid_new;
				k_d   = start_q;
			end
			ST_MERGE: begin
				waddr = k_q[AW-1:0];
				wdata = take_q ? src_q : src_p;
				we_a  = par_q;
				we_b  = !par_q;
				k_d   = k_inc;
				if (take_q) q_d = q_inc;
				else        p_d = p_inc;
				if (run_end) begin
					start_d = hi_q;
					if (pass_end) begin
						par_d   = !par_q;
						width_d = w2[CW-1:0];
						start_d = '0;
						if (!more_pass) p_d = '0;
					end
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_item.valid = 1'b1;
					p_d = p_inc;
					if (emit_last) begin
						cnt_d  = '0;
						drop_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_LOAD);
	assign raddr0   = p_d[AW-1:0];
	assign raddr1   = q_d[AW-1:0];

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			n_q     <= '0;
			width_q <= '0;
			start_q <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			p_q     <= '0;
			q_q     <= '0;
			k_q     <= '0;
			par_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
			n_q     <= n_d;
			width_q <= width_d;
			start_q <= start_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
			p_q     <= p_d;
			q_q     <= q_d;
			k_q     <= k_d;
			par_q   <= par_d;
		end
	end

endmodule

/* rtl/core/bums_checker.sv */
// -----------------------------------------------------------------------------
// bums_checker
// Port-level checks on the merge sort block, bound to the top level.
// -----------------------------------------------------------------------------
module bums_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// a closing input transaction starts the sort, so input stalls next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still ready after end of set");

	// no input is taken while a set is still being emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of an output set");

	// overflow flag is constant across one output set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tuser == $past(m_tuser)))
		else $error("overflow flag changed within a set");

	// a stalled output transaction holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output payload changed while stalled");

endmodule

bind bottom_up_merge_sort bums_checker u_bums_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

/* tb/bottom_up_merge_sort_checker.sv */
// -----------------------------------------------------------------------------
// bottom_up_merge_sort_checker
// Watches both streams of the sorter, keeps its own copy of the collected set,
// predicts the sorted output of each set and compares every output transaction.
// -----------------------------------------------------------------------------
module bottom_up_merge_sort_checker #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [bums_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [bums_pkg::DATA_W-1:0]   m_tdata,   // [31:0] sorted_value
	input  logic                          m_tlast,
	input  logic                          m_tuser,   // [0] overflow
	output int                            mismatch_count,
	output int                            sorted_pending,
	output int                            sorted_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import bums_pkg::*;

	// one expected output element
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} sorted_elem_t;

	// collected set and the sorted elements still to come out
	logic signed [DATA_W-1:0] set_store [MAX_ITEMS];
	int                       set_count;
	logic                     set_dropped;
	sorted_elem_t             sorted_due [$];

	// stable ascending sort of the collected set, queued as expected output
	task automatic sort_and_queue();
		logic signed [DATA_W-1:0] key;
		sorted_elem_t             elem;
		int                       i;
		int                       j;
		for (i = 1; i < set_count; i++) begin
			key = set_store[i];
			j = i - 1;
			// strict compare keeps equal elements in arrival order
			while (j >= 0 && set_store[j] > key) begin
				set_store[j + 1] = set_store[j];
				j--;
			end
			set_store[j + 1] = key;
		end
		for (i = 0; i < set_count; i++) begin
			elem.value = set_store[i];
			elem.last  = (i == set_count - 1);
			elem.ovf   = set_dropped;
			sorted_due.push_back(elem);
		end
		set_count   = 0;
		set_dropped = 1'b0;
	endtask

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		sorted_elem_t due;
		if (!arst_n) begin
			set_count      = 0;
			set_dropped    = 1'b0;
			sorted_due.delete();
			mismatch_count = 0;
			sorted_checked = 0;
			sorted_pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				// a full buffer drops the element, final one included
				if (set_count < MAX_ITEMS) begin
					set_store[set_count] = s_tdata;
					set_count++;
				end else begin
					set_dropped = 1'b1;
				end
				if (s_tlast)
					sort_and_queue();
			end
			if (m_tvalid && m_tready) begin
				if (sorted_due.size() == 0) begin
					$error("output transaction with no sorted element expected: value %0d",
						$signed(m_tdata));
					mismatch_count++;
				end else begin
					due = sorted_due.pop_front();
					sorted_checked++;
					if ($signed(m_tdata) !== due.value) begin
						$error("sorted_value mismatch: expected %0d, got %0d",
							due.value, $signed(m_tdata));
						mismatch_count++;
					end
					if (m_tlast !== due.last) begin
						$error("last_out mismatch: expected %0b, got %0b", due.last, m_tlast);
						mismatch_count++;
					end
					if (m_tuser !== due.ovf) begin
						$error("overflow mismatch: expected %0b, got %0b", due.ovf, m_tuser);
						mismatch_count++;
					end
				end
			end
			sorted_pending = sorted_due.size();
		end
	end

endmodule

/* tb/bottom_up_merge_sort_tb.sv */
// -----------------------------------------------------------------------------
// bottom_up_merge_sort_tb
// Streams sets of signed elements into the sorter with random gaps and output
// stalls; a checker beside the block predicts and compares every sorted element.
// -----------------------------------------------------------------------------
module bottom_up_merge_sort_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bums_pkg::*;

	localparam int SET_CAP     = 64;
	localparam int ITEM_TARGET = 380;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata;   // [31:0] value
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [DATA_W-1:0]   m_tdata;   // [31:0] sorted_value
	logic                m_tlast;
	logic                m_tuser;   // [0] overflow

	int mismatch_count;
	int sorted_pending;
	int sorted_checked;
	int items_sent;
	int sets_sent;
	int overflow_sets;
	int hold_left;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bottom_up_merge_sort #(
		.MAX_ITEMS (SET_CAP)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	bottom_up_merge_sort_checker #(
		.MAX_ITEMS (SET_CAP)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.sorted_pending (sorted_pending),
		.sorted_checked (sorted_checked)
	);

	// element values: ties, extremes and full-range patterns
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: pick_value = $urandom_range(0, 8) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: pick_value = 32'h8000_0000;
					1: pick_value = 32'h7fff_ffff;
					2: pick_value = 32'hffff_ffff;
					default: pick_value = 32'h0000_0000;
				endcase
			end
			default: pick_value = $urandom;
		endcase
	endfunction

	// one input transaction after an idle gap
	task automatic send_element(input logic [DATA_W-1:0] value, input logic last, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// one set of fixed values, last marked on the final element
	task automatic send_fixed_set(input logic [DATA_W-1:0] values [$]);
		int i;
		for (i = 0; i < values.size(); i++)
			send_element(values[i], i == values.size() - 1, $urandom_range(0, 13));
		sets_sent++;
	endtask

	// one set of random values, some sets sent back to back with no gaps
	task automatic send_random_set(input int size);
		bit quiet;
		int i;
		quiet = ($urandom_range(0, 3) == 0);
		for (i = 0; i < size; i++)
			send_element(pick_value(), i == size - 1, quiet ? 0 : $urandom_range(0, 13));
		sets_sent++;
		if (size > SET_CAP)
			overflow_sets++;
	endtask

	// output side: random stalls per transaction, with stall-free bursts
	initial begin
		int stall;
		m_tready  = 1'b0;
		hold_left = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_left > 0) begin
				stall = 0;
				hold_left--;
			end else if ($urandom_range(0, 19) == 0) begin
				stall     = 0;
				hold_left = $urandom_range(10, 40);
			end else begin
				stall = $urandom_range(0, 13);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// stimulus and verdict
	initial begin
		int size;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		items_sent    = 0;
		sets_sent     = 0;
		overflow_sets = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element, the most negative value
		send_fixed_set('{32'h8000_0000});
		// extremes mixed with duplicates to exercise tie order
		send_fixed_set('{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
			32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h0000_0005, 32'h0000_0005});
		// two already in order
		send_fixed_set('{32'hffff_fffd, 32'h0000_0007});
		// strictly descending, crossing zero
		send_fixed_set('{32'h4, 32'h3, 32'h2, 32'h1, 32'h0, 32'hffff_ffff, 32'hffff_fffe});

		// exactly full, then one over so the final element is dropped
		send_random_set(SET_CAP);
		send_random_set(SET_CAP + 1);

		// random sets, mostly small, a few full or overflowing
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0:          size = $urandom_range(SET_CAP + 1, SET_CAP + 8);
				1, 2:       size = $urandom_range(33, SET_CAP);
				3, 4, 5, 6: size = $urandom_range(9, 32);
				default:    size = $urandom_range(1, 8);
			endcase
			send_random_set(size);
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// drain, then watch for stray output
		repeat (2) @(posedge clk);
		wait (sorted_pending == 0);
		repeat (50) @(posedge clk);

		$display("covered %0d sets (%0d overflowing), %0d input elements", sets_sent,
			overflow_sets, items_sent);
		$display("checked %0d sorted output transactions, %0d mismatches", sorted_checked,
			mismatch_count);
		if (mismatch_count == 0 && sorted_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout with %0d sorted elements outstanding", sorted_pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule
